// ===== rtl/mrs_pkg.sv =====
// shared types, codes and the crc-16 byte step for the modbus rtu slave engine
// no dependencies; compiled first
package mrs_pkg;

    // input item kinds
    typedef enum logic [1:0] {
        K_RX_BYTE  = 2'd0,
        K_IDLE_GAP = 2'd1,
        K_RD_DATA  = 2'd2,
        K_TX_DONE  = 2'd3
    } t_in_kind;

    // result kinds
    localparam logic [1:0] OK_TX      = 2'd0;
    localparam logic [1:0] OK_WR      = 2'd1;
    localparam logic [1:0] OK_CRC_ERR = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_STATION    = 8'd0;
    localparam logic [7:0] CFG_FUNC_COUNT = 8'd1;

    // function codes
    localparam logic [7:0] FC_READ   = 8'd3;
    localparam logic [7:0] FC_WRITE  = 8'd16;
    localparam logic [7:0] FC_EXC    = 8'h80;

    // exception codes
    localparam logic [1:0] EXC_NONE      = 2'd0;
    localparam logic [1:0] EXC_ILL_FUNC  = 2'd1;
    localparam logic [1:0] EXC_ILL_ADDR  = 2'd2;
    localparam logic [1:0] EXC_ILL_VALUE = 2'd3;

    // result batch sizing
    localparam int BATCH_MAX   = 8;
    localparam int BATCH_IDX_W = 3;
    localparam int BATCH_CNT_W = 4;

    // what a queued result entry does when it goes out
    typedef enum logic [1:0] {
        E_DATA   = 2'd0,
        E_TX     = 2'd1,
        E_CRC_LO = 2'd2,
        E_CRC_HI = 2'd3
    } t_ent_kind;

    typedef struct packed {
        t_ent_kind   ekind;
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [4:0]  func_index;
        logic [3:0]  byte_offset;
    } t_entry;

    localparam t_entry ENTRY_NONE = '{
        ekind: E_DATA, out_kind: OK_TX, out_byte: 8'h00,
        func_index: 5'd0, byte_offset: 4'd0
    };

    // channel payloads
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [4:0] func_index;
        logic [3:0] byte_offset;
        logic [7:0] crc_error_count;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] reg_index;
        logic [7:0] wr_data;
    } t_cfg_write;

    // queue status toward the engine
    typedef struct packed {
        logic       room;
        logic       crc_step;
        logic [7:0] crc_byte;
    } t_q_stat;

    // crc-16/modbus, reflected poly 0xa001, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 16'hA001;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic t_entry mk_tx(input logic [7:0] b);
        t_entry e;
        e = ENTRY_NONE;
        e.ekind = E_TX;
        e.out_byte = b;
        return e;
    endfunction

    function automatic t_entry mk_crc(input t_ent_kind k);
        t_entry e;
        e = ENTRY_NONE;
        e.ekind = k;
        return e;
    endfunction

    function automatic t_entry mk_data(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [4:0] fi, input logic [3:0] off);
        t_entry e;
        e = ENTRY_NONE;
        e.out_kind = kind;
        e.out_byte = b;
        e.func_index = fi;
        e.byte_offset = off;
        return e;
    endfunction

endpackage

// ===== rtl/mrs_chan_if.sv =====
// valid/ready channel carrying one payload of type T per beat
// depends on nothing; payload types come from mrs_pkg at instantiation
interface mrs_chan_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mrs_result_queue.sv =====
// result queue: holds the batch of results of one item and sends one per beat
// depends on mrs_pkg and mrs_chan_if
module mrs_result_queue
    import mrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [BATCH_CNT_W-1:0] i_cnt,
    input  t_entry                 i_batch [BATCH_MAX],
    input  logic [15:0]            i_crc,
    input  logic [7:0]             i_err_count,
    output t_q_stat                o_stat,
    mrs_chan_if.source             o_out
);

    logic [BATCH_CNT_W-1:0] r_count;
    logic [BATCH_IDX_W-1:0] r_rd;
    t_entry                 r_ent [BATCH_MAX];
    t_entry                 cur;
    logic                   take;

    assign cur  = r_ent[r_rd];
    assign take = o_out.valid && o_out.ready;

    always_comb begin
        o_out.valid                = (r_count != '0);
        o_out.data.out_kind        = cur.out_kind;
        o_out.data.func_index      = cur.func_index;
        o_out.data.byte_offset     = cur.byte_offset;
        o_out.data.crc_error_count = i_err_count;
        o_out.data.last            = (r_count == BATCH_CNT_W'(1));
        case (cur.ekind)
            E_CRC_LO: o_out.data.out_byte = i_crc[7:0];
            E_CRC_HI: o_out.data.out_byte = i_crc[15:8];
            default:  o_out.data.out_byte = cur.out_byte;
        endcase
    end

    // a crc-carrying byte leaving the queue updates the engine crc, so a new
    // item is not taken on that byte's beat and so never sees the stale value
    always_comb begin
        o_stat.room     = (r_count == '0) ||
                          ((r_count == BATCH_CNT_W'(1)) && o_out.ready && (cur.ekind != E_TX));
        o_stat.crc_step = take && (cur.ekind == E_TX);
        o_stat.crc_byte = cur.out_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
        end else if (i_load && (i_cnt != '0)) begin
            r_count <= i_cnt;
            r_rd    <= '0;
        end else if (take) begin
            r_count <= r_count - BATCH_CNT_W'(1);
            r_rd    <= r_rd + BATCH_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (i_cnt != '0)) begin
            r_ent <= i_batch;
        end
    end

endmodule

// ===== rtl/modbus_rtu_slave_frame_engine_top.sv =====
// modbus rtu slave frame engine, holding-register functions 3 and 16 only
// depends on mrs_pkg, mrs_chan_if and mrs_result_queue
//
//  channel  dir  payload                                         beat when
//  i_in     in   kind, data_byte                                 valid && ready
//  o_out    out  out_kind, out_byte, func_index, byte_offset,    valid && ready
//                crc_error_count, last
//  i_cfg    in   reg_index, wr_data                              valid && ready
//
// one item is taken per cycle while the result queue has room; an item that yields n results holds
// the queue for n output beats, and the next item enters on the beat of the last one unless it is a header byte
// after the read-response header the crc of its last byte is registered as that byte leaves,
// so the first read data byte enters in the cycle after that header drains
// reset is synchronous, active low; no memories, so no clearing pass
// a stalled output keeps the queue full and holds off i_in; i_cfg is always ready
module modbus_rtu_slave_frame_engine_top
    import mrs_pkg::*;
#(
    parameter int BLOCK_BYTES = 16,
    parameter int MAX_SLOTS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrs_chan_if.sink   i_in,
    mrs_chan_if.source o_out,
    mrs_chan_if.sink   i_cfg
);

    localparam int BLOCK_REGS = BLOCK_BYTES / 2;
    localparam int LEFT_W     = $clog2(BLOCK_BYTES + 1);
    // reciprocal of BLOCK_REGS; 8-bit dividend plus up to 4 divisor bits
    localparam int DIV_SH     = 12;
    localparam int DIV_M      = ((1 << DIV_SH) + BLOCK_REGS - 1) / BLOCK_REGS;

    // frame phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_REGS      = 8'b0000_0010,
        PH_RX_STREAM = 8'b0000_0100,
        PH_CHECK_CRC = 8'b0000_1000,
        PH_WAIT_IDLE = 8'b0001_0000,
        PH_WAIT_RESP = 8'b0010_0000,
        PH_TX_STREAM = 8'b0100_0000,
        PH_FLUSH     = 8'b1000_0000
    } t_phase;

    // configuration
    logic [7:0] r_station;
    logic [5:0] r_func_count;

    // frame state
    t_phase              r_phase,     n_phase;
    logic [2:0]          r_fc,        n_fc;
    logic [15:0]         r_crc,       n_crc;
    logic [7:0]          r_func_code, n_func_code;
    logic [1:0]          r_exc,       n_exc;
    logic [7:0]          r_blk_low,   n_blk_low;
    logic [4:0]          r_slot,      n_slot;
    logic [LEFT_W-1:0]   r_left,      n_left;
    logic [7:0]          r_cap,       n_cap;
    logic [7:0]          r_err,       n_err;

    // result batch of the item being taken
    t_entry                 b_ent [BATCH_MAX];
    logic [BATCH_CNT_W-1:0] b_cnt;

    t_q_stat     q_stat;
    logic        accept;
    logic [7:0]  in_b;
    logic [5:0]  slots;
    logic [19:0] dv_prod;
    logic [7:0]  dv_rem;
    logic [7:0]  dv_q;
    logic [15:0] crc_in;
    logic [LEFT_W-1:0] left_dec;
    logic [3:0]  off_cur;
    logic [1:0]  exc_v;

    assign i_in.ready  = q_stat.room;
    assign accept      = i_in.valid && i_in.ready;
    assign in_b        = i_in.data.data_byte;
    assign i_cfg.ready = 1'b1;

    assign slots    = (r_func_count > 6'(MAX_SLOTS)) ? 6'(MAX_SLOTS) : r_func_count;
    assign crc_in   = crc16_step(r_crc, in_b);
    assign left_dec = (r_left != '0) ? r_left - LEFT_W'(1) : r_left;
    assign off_cur  = 4'(LEFT_W'(BLOCK_BYTES) - r_left);

    // register address low byte split into block number and remainder
    always_comb begin
        dv_prod = 20'(in_b) * 20'(DIV_M);
        dv_q    = dv_prod[DIV_SH +: 8];
        dv_rem  = in_b - 8'(dv_q * 8'(BLOCK_REGS));
    end

    // next state and result batch for the item at the input
    always_comb begin
        n_phase     = r_phase;
        n_fc        = r_fc;
        n_crc       = r_crc;
        n_func_code = r_func_code;
        n_exc       = r_exc;
        n_blk_low   = r_blk_low;
        n_slot      = r_slot;
        n_left      = r_left;
        n_cap       = r_cap;
        n_err       = r_err;
        exc_v       = r_exc;
        b_cnt       = '0;
        for (int k = 0; k < BATCH_MAX; k++) begin
            b_ent[k] = ENTRY_NONE;
        end

        case (t_in_kind'(i_in.data.kind))
            K_RX_BYTE: begin
                case (r_phase)
                    PH_IDLE: begin
                        if (r_fc == 3'd0) begin
                            // station address byte opens the frame
                            n_crc = crc16_step(16'hFFFF, in_b);
                            n_exc = EXC_NONE;
                            n_cap = in_b;
                            n_fc  = 3'd1;
                        end else begin
                            n_crc = crc_in;
                            n_fc  = 3'd0;
                            if (r_cap != r_station) begin
                                n_phase = PH_WAIT_IDLE;
                            end else begin
                                n_func_code = in_b;
                                if (in_b == FC_READ || in_b == FC_WRITE) begin
                                    n_phase = PH_REGS;
                                end else begin
                                    n_exc   = EXC_ILL_FUNC;
                                    n_phase = PH_WAIT_RESP;
                                end
                            end
                        end
                    end
                    PH_REGS: begin
                        n_crc = crc_in;
                        case (r_fc)
                            3'd0: begin
                                n_cap = in_b;
                                n_fc  = 3'd1;
                            end
                            3'd1: begin
                                n_blk_low = in_b;
                                n_slot    = dv_q[4:0];
                                if (r_cap != 8'd0 || dv_rem != 8'd0 || dv_q >= {2'b00, slots}) begin
                                    n_exc = EXC_ILL_ADDR;
                                end
                                n_fc = 3'd2;
                            end
                            3'd2: begin
                                n_cap = in_b;
                                n_fc  = 3'd3;
                            end
                            3'd3: begin
                                if (r_exc == EXC_NONE &&
                                    (r_cap != 8'd0 || in_b != 8'(BLOCK_REGS))) begin
                                    exc_v = EXC_ILL_VALUE;
                                end
                                n_exc  = exc_v;
                                n_fc   = 3'd0;
                                n_left = LEFT_W'(BLOCK_BYTES);
                                if (exc_v != EXC_NONE) begin
                                    n_phase = PH_WAIT_RESP;
                                end else if (r_func_code == FC_READ) begin
                                    n_phase = PH_CHECK_CRC;
                                end else begin
                                    n_fc = 3'd4;
                                end
                            end
                            default: begin
                                // byte count of a write request
                                n_fc = 3'd0;
                                if (in_b != 8'(BLOCK_BYTES)) begin
                                    n_exc   = EXC_ILL_VALUE;
                                    n_phase = PH_WAIT_RESP;
                                end else begin
                                    n_phase = PH_RX_STREAM;
                                end
                            end
                        endcase
                    end
                    PH_RX_STREAM: begin
                        n_crc    = crc_in;
                        b_ent[0] = mk_data(OK_WR, in_b, r_slot, off_cur);
                        b_cnt    = BATCH_CNT_W'(1);
                        n_left   = left_dec;
                        if (left_dec == '0) begin
                            n_phase = PH_CHECK_CRC;
                            n_fc    = 3'd0;
                        end
                    end
                    PH_CHECK_CRC: begin
                        if (r_fc == 3'd0) begin
                            n_cap = in_b;
                            n_fc  = 3'd1;
                        end else begin
                            n_fc = 3'd0;
                            if ({in_b, r_cap} == r_crc) begin
                                n_exc   = EXC_NONE;
                                n_phase = PH_WAIT_RESP;
                            end else begin
                                // written bytes stay written; report and wait for the gap
                                n_err    = r_err + 8'd1;
                                b_ent[0] = mk_data(OK_CRC_ERR, 8'h00, 5'd0, 4'd0);
                                b_cnt    = BATCH_CNT_W'(1);
                                n_phase  = PH_WAIT_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            K_IDLE_GAP: begin
                if (r_phase == PH_WAIT_RESP) begin
                    // response header; crc bytes are filled in as they leave
                    n_crc    = 16'hFFFF;
                    b_ent[0] = mk_tx(r_station);
                    if (r_exc != EXC_NONE) begin
                        b_ent[1] = mk_tx(r_func_code | FC_EXC);
                        b_ent[2] = mk_tx({6'b00_0000, r_exc});
                        b_ent[3] = mk_crc(E_CRC_LO);
                        b_ent[4] = mk_crc(E_CRC_HI);
                        b_cnt    = BATCH_CNT_W'(5);
                        n_phase  = PH_FLUSH;
                    end else if (r_func_code == FC_READ) begin
                        b_ent[1] = mk_tx(FC_READ);
                        b_ent[2] = mk_tx(8'(BLOCK_BYTES));
                        b_cnt    = BATCH_CNT_W'(3);
                        n_left   = LEFT_W'(BLOCK_BYTES);
                        n_phase  = PH_TX_STREAM;
                    end else begin
                        b_ent[1] = mk_tx(FC_WRITE);
                        b_ent[2] = mk_tx(8'h00);
                        b_ent[3] = mk_tx(r_blk_low);
                        b_ent[4] = mk_tx(8'h00);
                        b_ent[5] = mk_tx(8'(BLOCK_REGS));
                        b_ent[6] = mk_crc(E_CRC_LO);
                        b_ent[7] = mk_crc(E_CRC_HI);
                        b_cnt    = BATCH_CNT_W'(8);
                        n_phase  = PH_FLUSH;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_fc    = 3'd0;
                    n_crc   = 16'hFFFF;
                end
            end
            K_RD_DATA: begin
                if (r_phase == PH_TX_STREAM) begin
                    n_crc    = crc_in;
                    b_ent[0] = mk_data(OK_TX, in_b, r_slot, off_cur);
                    b_cnt    = BATCH_CNT_W'(1);
                    n_left   = left_dec;
                    if (left_dec == '0) begin
                        b_ent[1] = mk_crc(E_CRC_LO);
                        b_ent[2] = mk_crc(E_CRC_HI);
                        b_cnt    = BATCH_CNT_W'(3);
                        n_phase  = PH_FLUSH;
                    end
                end
            end
            default: begin
                // transmit done
                if (r_phase == PH_FLUSH) begin
                    n_phase = PH_IDLE;
                    n_fc    = 3'd0;
                    n_crc   = 16'hFFFF;
                end
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station    <= 8'hFF;
            r_func_count <= 6'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.data.reg_index == CFG_STATION) begin
                r_station <= i_cfg.data.wr_data;
            end else if (i_cfg.data.reg_index == CFG_FUNC_COUNT) begin
                r_func_count <= i_cfg.data.wr_data[5:0];
            end
        end
    end

    // frame state; the crc also advances on transmitted header bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_fc        <= 3'd0;
            r_crc       <= 16'hFFFF;
            r_func_code <= 8'd0;
            r_exc       <= EXC_NONE;
            r_blk_low   <= 8'd0;
            r_slot      <= 5'd0;
            r_left      <= '0;
            r_cap       <= 8'd0;
            r_err       <= 8'd0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_fc        <= n_fc;
            r_crc       <= n_crc;
            r_func_code <= n_func_code;
            r_exc       <= n_exc;
            r_blk_low   <= n_blk_low;
            r_slot      <= n_slot;
            r_left      <= n_left;
            r_cap       <= n_cap;
            r_err       <= n_err;
        end else if (q_stat.crc_step) begin
            r_crc <= crc16_step(r_crc, q_stat.crc_byte);
        end
    end

    mrs_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_cnt       (b_cnt),
        .i_batch     (b_ent),
        .i_crc       (r_crc),
        .i_err_count (r_err),
        .o_stat      (q_stat),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // the crc cannot be owned by the engine and the queue in one cycle
    a_crc_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && q_stat.crc_step))
        else $error("crc updated by engine and queue together");

    // the mismatch counter moves only on the second crc byte of a request
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && i_in.data.kind == K_RX_BYTE && r_phase == PH_CHECK_CRC && r_fc != 3'd0)
        |=> $stable(r_err))
        else $error("crc error count changed outside a crc check");

    // a data stream phase always has bytes left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RX_STREAM || r_phase == PH_TX_STREAM) |-> (r_left != '0))
        else $error("stream phase with no bytes left");

    // an accepted response header always leaves results waiting next cycle
    a_resp_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.data.kind == K_IDLE_GAP && r_phase == PH_WAIT_RESP)
        |=> o_out.valid)
        else $error("response header produced no output");
`endif

endmodule
